FILE: rtl/pzth_pkg.sv
package pzth_pkg;

  localparam int TOTAL_WIDTH = 40;
  localparam int ZONES       = 7;
  localparam int BOUNDS      = 6;
  localparam int ZONE_W      = 3;
  localparam int FTP_W       = 12;
  localparam int BOUND_W     = 10;
  localparam int POWER_W     = 12;
  localparam int TIME_W      = 32;
  localparam int SCALED_W    = 19;
  localparam int THR_W       = FTP_W + BOUND_W;
  // twice a 32-bit span needs 33 bits; one spare keeps the sum exact
  localparam int WEIGHT_W    = TIME_W + 2;
  localparam int SUM_W       = ((TOTAL_WIDTH > WEIGHT_W) ? TOTAL_WIDTH : WEIGHT_W) + 1;

  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;

  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;

  localparam logic [REG_IDX_W-1:0] REG_FTP     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_4 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_5 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_6 = 3'd6;

  localparam logic [FTP_W-1:0] FTP_RESET = 12'd200;
  localparam logic [BOUNDS-1:0][BOUND_W-1:0] BOUND_RESET =
    {10'd150, 10'd120, 10'd105, 10'd90, 10'd75, 10'd55};

  localparam logic [SCALED_W-1:0] POWER_SCALE       = 19'd100;
  localparam logic [WEIGHT_W-1:0] ONE_SECOND_HALF_MS = 34'd2000;

  localparam logic [ZONE_W-1:0] ZONE_NONE = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_TOP  = 3'd7;

  typedef logic [BOUNDS-1:0][THR_W-1:0] thr_t;

  typedef struct packed {
    thr_t thr;
    logic ftp_zero;
  } zone_cfg_t;

  typedef struct packed {
    logic [ZONE_W-1:0]   zone;
    logic [WEIGHT_W-1:0] weight;
  } acc_op_t;

  typedef struct packed {
    acc_op_t held;
    acc_op_t own;
    logic    ride_end;
  } q_word_t;

endpackage

FILE: rtl/pzth_cfg.sv
module pzth_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pzth_pkg::ADDR_W-1:0]   paddr,
  input  logic [pzth_pkg::DATA_W-1:0]   pwdata,
  output logic [pzth_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pzth_pkg::zone_cfg_t           zone_cfg
);

  logic [pzth_pkg::FTP_W-1:0]                         ftp_watts;
  logic [pzth_pkg::BOUNDS-1:0][pzth_pkg::BOUND_W-1:0] bound;
  logic [pzth_pkg::REG_IDX_W-1:0]                     reg_idx;
  logic                                               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pzth_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ftp_watts <= pzth_pkg::FTP_RESET;
      bound     <= pzth_pkg::BOUND_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        pzth_pkg::REG_FTP:     ftp_watts <= pwdata[pzth_pkg::FTP_W-1:0];
        pzth_pkg::REG_BOUND_1: bound[0]  <= pwdata[pzth_pkg::BOUND_W-1:0];
        pzth_pkg::REG_BOUND_2: bound[1]  <= pwdata[pzth_pkg::BOUND_W-1:0];
        pzth_pkg::REG_BOUND_3: bound[2]  <= pwdata[pzth_pkg::BOUND_W-1:0];
        pzth_pkg::REG_BOUND_4: bound[3]  <= pwdata[pzth_pkg::BOUND_W-1:0];
        pzth_pkg::REG_BOUND_5: bound[4]  <= pwdata[pzth_pkg::BOUND_W-1:0];
        pzth_pkg::REG_BOUND_6: bound[5]  <= pwdata[pzth_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // boundary thresholds in watts*100, one multiplier per boundary
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pzth_pkg::BOUNDS; i++) begin
        zone_cfg.thr[i] <= pzth_pkg::THR_W'(pzth_pkg::BOUND_RESET[i]) *
                           pzth_pkg::THR_W'(pzth_pkg::FTP_RESET);
      end
      zone_cfg.ftp_zero <= 1'b0;
    end else begin
      for (int i = 0; i < pzth_pkg::BOUNDS; i++) begin
        zone_cfg.thr[i] <= pzth_pkg::THR_W'(bound[i]) * pzth_pkg::THR_W'(ftp_watts);
      end
      zone_cfg.ftp_zero <= (ftp_watts == '0);
    end
  end

  always_comb begin
    unique case (reg_idx)
      pzth_pkg::REG_FTP:     prdata = pzth_pkg::DATA_W'(ftp_watts);
      pzth_pkg::REG_BOUND_1: prdata = pzth_pkg::DATA_W'(bound[0]);
      pzth_pkg::REG_BOUND_2: prdata = pzth_pkg::DATA_W'(bound[1]);
      pzth_pkg::REG_BOUND_3: prdata = pzth_pkg::DATA_W'(bound[2]);
      pzth_pkg::REG_BOUND_4: prdata = pzth_pkg::DATA_W'(bound[3]);
      pzth_pkg::REG_BOUND_5: prdata = pzth_pkg::DATA_W'(bound[4]);
      pzth_pkg::REG_BOUND_6: prdata = pzth_pkg::DATA_W'(bound[5]);
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: rtl/pzth_front.sv
module pzth_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          power_valid,
  input  logic [pzth_pkg::POWER_W-1:0]  power_watts,
  input  logic [pzth_pkg::TIME_W-1:0]   time_ms,
  input  logic                          ride_end,
  input  pzth_pkg::zone_cfg_t           zone_cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output pzth_pkg::q_word_t             q_data
);

  logic                          s1_valid;
  logic                          s1_pvalid;
  logic [pzth_pkg::POWER_W-1:0]  s1_power;
  logic [pzth_pkg::TIME_W-1:0]   s1_time;
  logic                          s1_end;

  logic [pzth_pkg::TIME_W-1:0]   earlier_time;
  logic [pzth_pkg::TIME_W-1:0]   held_time;
  logic [pzth_pkg::ZONE_W-1:0]   held_zone;
  logic [1:0]                    samples_seen;

  logic                          accept;
  logic                          advance;
  logic [pzth_pkg::SCALED_W-1:0] scaled;
  logic [pzth_pkg::BOUNDS-1:0]   below;
  logic [pzth_pkg::ZONE_W-1:0]   zone;
  logic [pzth_pkg::TIME_W-1:0]   span_held;
  logic [pzth_pkg::TIME_W-1:0]   span_early;
  logic [pzth_pkg::WEIGHT_W-1:0] span_held_x2;

  assign advance  = s1_valid && !q_full;
  assign in_stall = s1_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pvalid <= power_valid;
      s1_power  <= power_watts;
      s1_time   <= time_ms;
      s1_end    <= ride_end;
    end
  end

  // zone classification against the registered thresholds; lowest match wins
  always_comb begin
    scaled = pzth_pkg::SCALED_W'(s1_power) * pzth_pkg::POWER_SCALE;
    for (int i = 0; i < pzth_pkg::BOUNDS; i++) begin
      below[i] = pzth_pkg::THR_W'(scaled) < zone_cfg.thr[i];
    end
    zone = pzth_pkg::ZONE_NONE;
    if (!below[pzth_pkg::BOUNDS-1]) begin
      zone = pzth_pkg::ZONE_TOP;
    end
    for (int k = pzth_pkg::BOUNDS - 1; k >= 1; k--) begin
      if (!below[k-1] && below[k]) begin
        zone = pzth_pkg::ZONE_W'(k + 1);
      end
    end
    if (below[0]) begin
      zone = pzth_pkg::ZONE_W'(1);
    end
    if (!s1_pvalid || zone_cfg.ftp_zero) begin
      zone = pzth_pkg::ZONE_NONE;
    end
  end

  // backwards time gives zero weight
  assign span_held    = (s1_time > held_time)    ? s1_time - held_time    : '0;
  assign span_early   = (s1_time > earlier_time) ? s1_time - earlier_time : '0;
  assign span_held_x2 = pzth_pkg::WEIGHT_W'({span_held, 1'b0});

  always_comb begin
    q_push = advance;
    q_data.ride_end  = s1_end;
    q_data.held.zone = held_zone;
    if (samples_seen[1]) begin
      q_data.held.weight = pzth_pkg::WEIGHT_W'(span_early);
    end else if (samples_seen[0]) begin
      q_data.held.weight = span_held_x2;
    end else begin
      q_data.held.weight = '0;
    end
    q_data.own.zone   = s1_end ? zone : pzth_pkg::ZONE_NONE;
    q_data.own.weight = (samples_seen == 2'd0) ? pzth_pkg::ONE_SECOND_HALF_MS : span_held_x2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      earlier_time <= '0;
      held_time    <= '0;
      held_zone    <= pzth_pkg::ZONE_NONE;
      samples_seen <= 2'd0;
    end else if (advance) begin
      if (s1_end) begin
        earlier_time <= '0;
        held_time    <= '0;
        held_zone    <= pzth_pkg::ZONE_NONE;
        samples_seen <= 2'd0;
      end else begin
        earlier_time <= held_time;
        held_time    <= s1_time;
        held_zone    <= zone;
        if (!samples_seen[1]) begin
          samples_seen <= samples_seen + 2'd1;
        end
      end
    end
  end

endmodule

FILE: rtl/pzth_queue.sv
module pzth_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pzth_pkg::q_word_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output pzth_pkg::q_word_t head
);

  pzth_pkg::q_word_t              slots [pzth_pkg::Q_DEPTH];
  logic [pzth_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [pzth_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [pzth_pkg::Q_CNT_W-1:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count == pzth_pkg::Q_CNT_W'(pzth_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/pzth_back.sv
module pzth_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  pzth_pkg::q_word_t                 q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pzth_pkg::ZONE_W-1:0]       zone_number,
  output logic [pzth_pkg::TOTAL_WIDTH-1:0]  zone_time,
  output logic                              last_zone
);

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_OWN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [pzth_pkg::ZONE_W-1:0] LAST_IDX = pzth_pkg::ZONE_W'(pzth_pkg::ZONES - 1);
  localparam logic [pzth_pkg::SUM_W-1:0]  TOTAL_MAX =
    pzth_pkg::SUM_W'({pzth_pkg::TOTAL_WIDTH{1'b1}});

  logic [1:0]                           state;
  logic [pzth_pkg::ZONE_W-1:0]          emit_idx;
  logic [pzth_pkg::TOTAL_WIDTH-1:0]     totals [pzth_pkg::ZONES];
  pzth_pkg::acc_op_t                    pend;

  pzth_pkg::acc_op_t                    cur_op;
  logic                                 zone_ok;
  logic                                 apply_en;
  logic [pzth_pkg::ZONE_W-1:0]          rd_idx;
  logic [pzth_pkg::TOTAL_WIDTH-1:0]     sel_total;
  logic [pzth_pkg::SUM_W-1:0]           sum;
  logic [pzth_pkg::TOTAL_WIDTH-1:0]     sat;
  logic                                 out_load;
  logic                                 emit_done;

  assign q_pop     = (state == ST_ACC) && !q_empty;
  assign cur_op    = (state == ST_OWN) ? pend : q_head.held;
  assign zone_ok   = (cur_op.zone != pzth_pkg::ZONE_NONE);
  assign apply_en  = ((state == ST_OWN) || q_pop) && zone_ok;
  assign out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign emit_done = out_load && (emit_idx == LAST_IDX);

  // one read port shared by accumulate and readout
  always_comb begin
    if (state == ST_EMIT) begin
      rd_idx = emit_idx;
    end else if (zone_ok) begin
      rd_idx = cur_op.zone - 1'b1;
    end else begin
      rd_idx = '0;
    end
  end

  assign sel_total = totals[rd_idx];
  assign sum = pzth_pkg::SUM_W'(sel_total) + pzth_pkg::SUM_W'(cur_op.weight);
  assign sat = (sum > TOTAL_MAX) ? {pzth_pkg::TOTAL_WIDTH{1'b1}}
                                 : sum[pzth_pkg::TOTAL_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst || emit_done) begin
      for (int i = 0; i < pzth_pkg::ZONES; i++) begin
        totals[i] <= '0;
      end
    end else if (apply_en) begin
      totals[rd_idx] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC: begin
          if (q_pop && q_head.ride_end) begin
            state <= ST_OWN;
          end
        end
        ST_OWN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            if (emit_idx == LAST_IDX) begin
              state    <= ST_ACC;
              emit_idx <= '0;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend <= q_head.own;
    end
    if (out_load) begin
      zone_number <= emit_idx + 1'b1;
      zone_time   <= sel_total;
      last_zone   <= (emit_idx == LAST_IDX);
    end
  end

endmodule

FILE: rtl/power_zone_time_histogram.sv
// Power time-in-zone histogram. Takes one sample word per cycle while
// in_stall is low; a sample is held until its successor arrives, then its
// time weight (in half milliseconds) is added to its zone. The word marked
// ride_end triggers seven result words, zones 1 to 7 in order, with
// last_zone on zone 7, after which the ride state is cleared. The
// accumulator first adds the held weight carried by the ride_end word, then
// that word's own weight, and then sends the result words (held while
// out_stall is high), and a four-word queue between classifier and
// accumulator keeps taking the next ride's samples meanwhile, so in_stall
// only rises when that queue fills. Threshold registers are recomputed from
// the stored configuration registers after a configuration write.
module power_zone_time_histogram (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              power_valid,
  input  logic [pzth_pkg::POWER_W-1:0]      power_watts,
  input  logic [pzth_pkg::TIME_W-1:0]       time_ms,
  input  logic                              ride_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pzth_pkg::ZONE_W-1:0]       zone_number,
  output logic [pzth_pkg::TOTAL_WIDTH-1:0]  zone_time,
  output logic                              last_zone,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pzth_pkg::ADDR_W-1:0]       paddr,
  input  logic [pzth_pkg::DATA_W-1:0]       pwdata,
  output logic [pzth_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  pzth_pkg::zone_cfg_t zone_cfg;
  pzth_pkg::q_word_t   q_in;
  pzth_pkg::q_word_t   q_head;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;

  pzth_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .zone_cfg (zone_cfg)
  );

  pzth_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .power_valid (power_valid),
    .power_watts (power_watts),
    .time_ms     (time_ms),
    .ride_end    (ride_end),
    .zone_cfg    (zone_cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  pzth_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  pzth_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .zone_number (zone_number),
    .zone_time   (zone_time),
    .last_zone   (last_zone)
  );

endmodule

FILE: rtl/pzth_checker.sv
module pzth_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [pzth_pkg::ZONE_W-1:0]       zone_number,
  input logic [pzth_pkg::TOTAL_WIDTH-1:0]  zone_time,
  input logic                              last_zone
);

  // a held word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(zone_number) && $stable(zone_time)
      && $stable(last_zone))
    else $error("result word changed while stalled");

  a_zone_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> zone_number != pzth_pkg::ZONE_NONE)
    else $error("zone number out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_zone == (zone_number == pzth_pkg::ZONE_TOP)))
    else $error("last_zone does not mark zone 7");

  // readout runs back to back through the zones
  a_zone_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_zone |=>
      out_valid && zone_number == $past(zone_number) + 3'd1)
    else $error("zone readout skipped or broke off");

  a_first_zone: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> zone_number == 3'd1)
    else $error("readout did not start at zone 1");

endmodule

bind power_zone_time_histogram pzth_checker u_pzth_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .zone_number (zone_number),
  .zone_time   (zone_time),
  .last_zone   (last_zone)
);

FILE: verif/zone_total_checker.sv
module zone_total_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              power_valid,
  input  logic [pzth_pkg::POWER_W-1:0]      power_watts,
  input  logic [pzth_pkg::TIME_W-1:0]       time_ms,
  input  logic                              ride_end,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [pzth_pkg::ZONE_W-1:0]       zone_number,
  input  logic [pzth_pkg::TOTAL_WIDTH-1:0]  zone_time,
  input  logic                              last_zone,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pzth_pkg::ADDR_W-1:0]       paddr,
  input  logic [pzth_pkg::DATA_W-1:0]       pwdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pzth_pkg::*;

  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  typedef struct {
    logic [ZONE_W-1:0]      zone;
    logic [TOTAL_WIDTH-1:0] total;
    logic                   last;
  } zone_report_t;

  logic [FTP_W-1:0]       ftp_now;
  logic [BOUND_W-1:0]     bound_now [BOUNDS];
  logic [TIME_W-1:0]      older_t;
  logic [TIME_W-1:0]      held_t;
  logic [ZONE_W-1:0]      pend_zone;
  int                     stamps;
  logic [TOTAL_WIDTH-1:0] zone_sum [ZONES];
  zone_report_t           reports_due [$];

  function automatic logic [ZONE_W-1:0] zone_of(logic pv, logic [POWER_W-1:0] watts);
    int unsigned scaled;
    int unsigned thr [BOUNDS];
    if (!pv || ftp_now == '0) return ZONE_NONE;
    scaled = 32'(watts) * 32'(POWER_SCALE);
    for (int k = 0; k < BOUNDS; k++) thr[k] = 32'(bound_now[k]) * 32'(ftp_now);
    // first match wins, so unordered bounds still resolve
    if (scaled < thr[0]) return ZONE_W'(1);
    for (int k = 1; k < BOUNDS; k++) begin
      if (scaled >= thr[k-1] && scaled < thr[k]) return ZONE_W'(k + 1);
    end
    if (scaled >= thr[BOUNDS-1]) return ZONE_TOP;
    return ZONE_NONE;
  endfunction

  function automatic logic [WEIGHT_W-1:0] span(logic [TIME_W-1:0] from_t,
                                               logic [TIME_W-1:0] to_t);
    return (to_t > from_t) ? WEIGHT_W'(to_t - from_t) : '0;
  endfunction

  function automatic void add_time(logic [ZONE_W-1:0] zone, logic [WEIGHT_W-1:0] weight);
    logic [63:0] room;
    if (zone == ZONE_NONE || zone > ZONE_TOP) return;
    room = 64'(TOTAL_MAX) - 64'(zone_sum[zone-1]);
    if (64'(weight) > room) zone_sum[zone-1] = TOTAL_MAX;
    else zone_sum[zone-1] = zone_sum[zone-1] + TOTAL_WIDTH'(weight);
  endfunction

  function automatic void start_new_ride();
    older_t   = '0;
    held_t    = '0;
    pend_zone = ZONE_NONE;
    stamps    = 0;
    for (int k = 0; k < ZONES; k++) zone_sum[k] = '0;
  endfunction

  always @(posedge clk) begin
    zone_report_t want;
    logic [ZONE_W-1:0] zone;
    if (rst) begin
      ftp_now = FTP_RESET;
      for (int k = 0; k < BOUNDS; k++) bound_now[k] = BOUND_RESET[k];
      start_new_ride();
      reports_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("zone report with none due: zone_number %0d zone_time %0d",
                 zone_number, zone_time);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          if (zone_number !== want.zone) begin
            $error("zone_number: expected %0d, got %0d", want.zone, zone_number);
            fail_count++;
          end
          if (zone_time !== want.total) begin
            $error("zone_time: expected %0d, got %0d", want.total, zone_time);
            fail_count++;
          end
          if (last_zone !== want.last) begin
            $error("last_zone: expected %0d, got %0d", want.last, last_zone);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        zone = zone_of(power_valid, power_watts);
        // settle the held sample now that its successor is known
        if (stamps == 1) add_time(pend_zone, span(held_t, time_ms) << 1);
        else if (stamps >= 2) add_time(pend_zone, span(older_t, time_ms));
        if (ride_end) begin
          add_time(zone, (stamps == 0) ? ONE_SECOND_HALF_MS : span(held_t, time_ms) << 1);
          for (int k = 0; k < ZONES; k++) begin
            reports_due.push_back('{zone: ZONE_W'(k + 1), total: zone_sum[k],
                                    last: (k == ZONES - 1)});
          end
          start_new_ride();
        end else begin
          older_t   = held_t;
          held_t    = time_ms;
          pend_zone = zone;
          if (stamps < 2) stamps++;
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_FTP: ftp_now = pwdata[FTP_W-1:0];
          REG_BOUND_1, REG_BOUND_2, REG_BOUND_3,
          REG_BOUND_4, REG_BOUND_5, REG_BOUND_6: begin
            bound_now[paddr[ADDR_W-1:2] - REG_BOUND_1] = pwdata[BOUND_W-1:0];
          end
          default: ;
        endcase
      end
    end
    reports_pending = reports_due.size();
  end

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pzth_pkg::*;

  localparam int RESET_CYCLES  = 10;
  localparam int DRAIN_CYCLES  = 24;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_ITEMS  = 200;
  localparam int SAT_SAMPLES   = 640;
  localparam int BOUND_MAX     = 1000;
  localparam int FTP_MAX       = (1 << FTP_W) - 1;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   power_valid = 1'b0;
  logic [POWER_W-1:0]     power_watts = '0;
  logic [TIME_W-1:0]      time_ms = '0;
  logic                   ride_end = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ZONE_W-1:0]      zone_number;
  logic [TOTAL_WIDTH-1:0] zone_time;
  logic                   last_zone;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;
  int                     fail_count;
  int                     reports_pending;

  bit steady = 1'b0;
  int cycle_count = 0;
  int samples_sent = 0;
  int stall_left = 0;
  int cur_ftp;
  int cur_bound [BOUNDS];

  power_zone_time_histogram dut (.*);
  zone_total_checker checker_i (.*);

  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 2) != 0) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= idle_len();
    end
  end

  task automatic send_sample(input logic pv, input logic [POWER_W-1:0] watts,
                             input logic [TIME_W-1:0] stamp, input logic last);
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    power_valid <= pv;
    power_watts <= watts;
    time_ms     <= stamp;
    ride_end    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold the sample side until every report is in and the queue has drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FTP) cur_ftp = int'(val[FTP_W-1:0]);
    else if (idx >= REG_BOUND_1 && idx <= REG_BOUND_6)
      cur_bound[idx - REG_BOUND_1] = int'(val[BOUND_W-1:0]);
  endtask

  task automatic load_zones(input int ftp, input int b [BOUNDS]);
    write_reg(REG_FTP, DATA_W'(ftp));
    for (int k = 0; k < BOUNDS; k++) write_reg(REG_IDX_W'(REG_BOUND_1 + k), DATA_W'(b[k]));
  endtask

  task automatic pick_zones();
    int f, r, x;
    int b [BOUNDS];
    r = $urandom_range(0, 9);
    if (r == 0) f = 0;
    else if (r == 1) f = FTP_MAX;
    else if (r < 6) f = $urandom_range(100, 400);
    else f = $urandom_range(1, FTP_MAX);
    for (int k = 0; k < BOUNDS; k++) begin
      if ($urandom_range(0, 9) == 0) b[k] = $urandom_range(0, 1) ? BOUND_MAX : 0;
      else b[k] = $urandom_range(0, BOUND_MAX);
    end
    // mostly ascending; the rest stay scrambled
    if ($urandom_range(0, 4) != 0) begin
      for (int i = 1; i < BOUNDS; i++) begin
        for (int j = i; j > 0 && b[j-1] > b[j]; j--) begin
          x = b[j];
          b[j] = b[j-1];
          b[j-1] = x;
        end
      end
    end
    load_zones(f, b);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
  endtask

  // half the time land right on a zone edge
  function automatic logic [POWER_W-1:0] pick_watts();
    int k, w;
    if ($urandom_range(0, 1) == 0 || cur_ftp == 0) return POWER_W'($urandom);
    k = $urandom_range(0, BOUNDS - 1);
    w = (cur_bound[k] * cur_ftp + int'(POWER_SCALE) - 1) / int'(POWER_SCALE)
        - int'($urandom_range(0, 1));
    if (w < 0) w = 0;
    if (w > (1 << POWER_W) - 1) w = (1 << POWER_W) - 1;
    return POWER_W'(w);
  endfunction

  function automatic logic [TIME_W-1:0] next_time(logic [TIME_W-1:0] t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return t + $urandom_range(1, 2000);
    if (r < 75) return t;
    if (r < 85) return t - $urandom_range(1, 5000);
    if (r < 95) return t + $urandom_range(0, 32'h00FF_FFFF);
    return $urandom;
  endfunction

  task automatic random_ride();
    int len, mid, r;
    logic [TIME_W-1:0] t;
    r = $urandom_range(0, 19);
    if (r < 3) len = 1;
    else if (r < 15) len = $urandom_range(2, 8);
    else len = $urandom_range(9, 24);
    mid = ($urandom_range(0, 9) == 0 && len > 2) ? $urandom_range(1, len - 2) : -1;
    t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
    steady = ($urandom_range(0, 6) == 0);
    for (int i = 0; i < len; i++) begin
      if (i == mid) begin
        settle();
        pick_zones();
      end
      send_sample($urandom_range(0, 9) != 0, pick_watts(), t, i == len - 1);
      t = next_time(t);
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL power_zone_time_histogram");
    $finish;
  end

  initial begin
    int zb [BOUNDS];
    cur_ftp = int'(FTP_RESET);
    for (int k = 0; k < BOUNDS; k++) cur_bound[k] = int'(BOUND_RESET[k]);
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lone sample counts one second
    send_sample(1'b1, 12'd0, 32'd12345, 1'b1);
    // one sample per zone, a dropout, end at the top of the time range
    send_sample(1'b1, 12'd0, 32'd0, 1'b0);
    send_sample(1'b1, 12'd110, 32'd1000, 1'b0);
    send_sample(1'b1, 12'd150, 32'd2000, 1'b0);
    send_sample(1'b1, 12'd180, 32'd3000, 1'b0);
    send_sample(1'b1, 12'd210, 32'd4000, 1'b0);
    send_sample(1'b1, 12'd240, 32'd5000, 1'b0);
    send_sample(1'b1, 12'hFFF, 32'd6000, 1'b0);
    send_sample(1'b0, 12'hFFF, 32'd7000, 1'b0);
    send_sample(1'b1, 12'd299, 32'hFFFF_FFFF, 1'b1);
    // clock running backwards
    send_sample(1'b1, 12'd160, 32'd5000, 1'b0);
    send_sample(1'b1, 12'd160, 32'd3000, 1'b0);
    send_sample(1'b1, 12'd400, 32'd1000, 1'b1);
    // ftp swapped mid-ride: zero, then full scale
    send_sample(1'b1, 12'd100, 32'd0, 1'b0);
    settle();
    write_reg(REG_FTP, '0);
    send_sample(1'b1, 12'd100, 32'd10, 1'b0);
    send_sample(1'b1, 12'hFFF, 32'd500, 1'b0);
    settle();
    write_reg(REG_FTP, DATA_W'(FTP_MAX));
    send_sample(1'b1, 12'hFFF, 32'd900, 1'b1);
    // whole ride at zero ftp
    settle();
    write_reg(REG_FTP, '0);
    send_sample(1'b1, 12'd2000, 32'd0, 1'b0);
    send_sample(1'b1, 12'd2000, 32'd400, 1'b1);
    // unordered bounds at the extremes; spare index must not land anywhere
    settle();
    load_zones(FTP_MAX, '{10, 5, 8, BOUND_MAX, 0, BOUND_MAX});
    write_reg(REG_SPARE, '1);
    send_sample(1'b1, 12'd0, 32'd100, 1'b0);
    send_sample(1'b1, 12'd500, 32'd200, 1'b0);
    send_sample(1'b1, 12'hFFF, 32'd300, 1'b1);
    settle();
    for (int k = 0; k < BOUNDS; k++) zb[k] = int'(BOUND_RESET[k]);
    load_zones(int'(FTP_RESET), zb);

    // long top-zone ride with big swings so the zone 7 total clamps
    steady = 1'b1;
    for (int i = 0; i < SAT_SAMPLES; i++)
      send_sample(1'b1, 12'hFFF, i[1] ? 32'hFFFF_FFFF : 32'h0, i == SAT_SAMPLES - 1);
    steady = 1'b0;

    samples_sent = 0;
    while (samples_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        pick_zones();
      end
      random_ride();
    end

    settle();
    if (fail_count == 0) $display("PASS power_zone_time_histogram");
    else $display("FAIL power_zone_time_histogram");
    $finish;
  end

endmodule
